[hw/rtl/utu8_pkg.sv]
package utu8_pkg;

  // Width of the per-text byte counter
  localparam int CountBits = 16;
  // Largest run of bytes one transaction can produce
  localparam int RunBytes = 6;
  localparam int RunIdxW = $clog2(RunBytes);
  localparam int RunLenW = $clog2(RunBytes + 1);

  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast = 16'hDBFF;
  localparam logic [15:0] LowFirst = 16'hDC00;
  localparam logic [15:0] LowLast = 16'hDFFF;
  localparam logic [20:0] SuppBase = 21'h10000;
  localparam logic [20:0] Replacement = 21'h00FFFD;
  localparam logic [20:0] Max1Byte = 21'h00007F;
  localparam logic [20:0] Max2Byte = 21'h0007FF;
  localparam logic [20:0] Max3Byte = 21'h00FFFF;
  localparam logic [7:0] Lead2 = 8'hC0;
  localparam logic [7:0] Lead3 = 8'hE0;
  localparam logic [7:0] Lead4 = 8'hF0;
  localparam logic [7:0] ContMark = 8'h80;

  typedef struct packed {
    logic [2:0] len;
    logic [3:0][7:0] b;
  } enc_t;

  // Per-text conversion state
  typedef struct packed {
    logic [9:0] pending_high;
    logic pending_valid;
    logic stopped;
    logic overflowed;
    logic [CountBits-1:0] byte_count;
  } txt_state_t;

  // Results of one transaction, held until delivered
  typedef struct packed {
    logic [RunBytes-1:0][7:0] bytes;
    logic [RunLenW-1:0] len;
    logic bare;
    logic last;
    logic trunc;
    logic [CountBits-1:0] base;
  } run_t;

  // UTF-8 encoding of one code point
  function automatic enc_t cp_to_bytes(input logic [20:0] cp);
    enc_t e;
    e.b = '0;
    if (cp <= Max1Byte) begin
      e.len = 3'd1;
      e.b[0] = cp[7:0];
    end else if (cp <= Max2Byte) begin
      e.len = 3'd2;
      e.b[0] = Lead2 | {3'b000, cp[10:6]};
      e.b[1] = ContMark | {2'b00, cp[5:0]};
    end else if (cp <= Max3Byte) begin
      e.len = 3'd3;
      e.b[0] = Lead3 | {4'b0000, cp[15:12]};
      e.b[1] = ContMark | {2'b00, cp[11:6]};
      e.b[2] = ContMark | {2'b00, cp[5:0]};
    end else begin
      e.len = 3'd4;
      e.b[0] = Lead4 | {5'b00000, cp[20:18]};
      e.b[1] = ContMark | {2'b00, cp[17:12]};
      e.b[2] = ContMark | {2'b00, cp[11:6]};
      e.b[3] = ContMark | {2'b00, cp[5:0]};
    end
    return e;
  endfunction

endpackage

[hw/rtl/utf16_to_utf8_transcoder.sv]
// Channel  Handshake             Payload
// in       in_valid / in_ready   code_unit, last_unit
// out      out_valid / out_ready out_byte, byte_valid, run_end, text_done,
//                                total_bytes, truncated
// config   cfg_we                cfg_wdata (out_capacity)
//
// A unit is decoded in the cycle it is accepted and its bytes (1 to 6) land in a run
// register; the run drains one byte per cycle while out_ready is high. A unit that
// yields nothing loads no run unless it is the last unit of its text.
// The next unit is accepted in the cycle the last byte of the run is taken.
// A stalled output holds the run and backs up the input. Synchronous reset
// clears the text state and the run and sets the capacity to 65535.
module utf16_to_utf8_transcoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] code_unit,
  input  logic        last_unit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        run_end,
  output logic        text_done,
  output logic [15:0] total_bytes,
  output logic        truncated
);
  import utu8_pkg::*;

  logic [15:0] out_capacity;
  txt_state_t state;
  txt_state_t state_next;
  run_t run_new;
  logic run_load;
  run_t run;
  logic run_valid;
  logic [RunIdxW-1:0] run_pos;
  logic [CountBits-1:0] run_total;
  logic in_take;
  logic out_take;

  utu8_step u_step (
    .state        (state),
    .out_capacity (out_capacity),
    .code_unit    (code_unit),
    .last_unit    (last_unit),
    .state_next   (state_next),
    .run          (run_new),
    .run_load     (run_load)
  );

  assign run_end = (RunLenW'(run_pos) == run.len - RunLenW'(1));
  assign out_take = run_valid && out_ready;
  assign in_ready = !run_valid || (out_ready && run_end);
  assign in_take = in_valid && in_ready;

  // Drive the result fields from the run register
  assign out_valid = run_valid;
  assign out_byte = run.bare ? 8'd0 : run.bytes[run_pos];
  assign byte_valid = !run.bare;
  assign text_done = run_end && run.last;
  assign total_bytes = 16'(run_total);
  assign truncated = run.trunc;

  // Hold the capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= 16'hFFFF;
    end else if (cfg_we) begin
      out_capacity <= cfg_wdata;
    end
  end

  // Advance the text state on each input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_take) begin
      state <= state_next;
    end
  end

  // Load a new run or step through the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      run_pos <= '0;
    end else if (in_take) begin
      run_valid <= run_load;
      run_pos <= '0;
    end else if (out_take) begin
      if (run_end) begin
        run_valid <= 1'b0;
      end else begin
        run_pos <= run_pos + RunIdxW'(1);
      end
    end
  end

  // Run payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      run <= run_new;
      run_total <= run_new.bare ? run_new.base : run_new.base + CountBits'(1);
    end else if (out_take && !run_end) begin
      run_total <= run_total + CountBits'(1);
    end
  end

endmodule

[hw/rtl/utu8_step.sv]
module utu8_step (
  input  utu8_pkg::txt_state_t state,
  input  logic [15:0]          out_capacity,
  input  logic [15:0]          code_unit,
  input  logic                 last_unit,
  output utu8_pkg::txt_state_t state_next,
  output utu8_pkg::run_t       run,
  output logic                 run_load
);
  import utu8_pkg::*;

  localparam int WideW = 33;
  localparam logic [WideW-1:0] CountMax = (WideW'(1) << CountBits) - WideW'(1);

  logic is_high;
  logic is_low;
  logic [WideW-1:0] cap_wide;
  logic [WideW-1:0] cap_use;
  logic [WideW-1:0] cnt_wide;
  logic [WideW-1:0] room;
  logic [WideW-1:0] room_b;
  logic want_a;
  logic want_b;
  logic fit_a;
  logic fit_b;
  logic [20:0] cp_a;
  logic [20:0] cp_b;
  logic [20:0] pair_cp;
  enc_t enc_a;
  enc_t enc_b;
  logic [2:0] len_a;
  logic [2:0] len_b;
  logic [RunLenW-1:0] total_len;
  logic [2:0] j;

  assign is_high = (code_unit >= HighFirst) && (code_unit <= HighLast);
  assign is_low = (code_unit >= LowFirst) && (code_unit <= LowLast);
  assign pair_cp = SuppBase + {1'b0, state.pending_high, code_unit[9:0]};

  // Usable capacity and room left
  assign cap_wide = {{(WideW-16){1'b0}}, out_capacity};
  assign cap_use = (cap_wide < CountMax) ? cap_wide : CountMax;
  assign cnt_wide = WideW'(state.byte_count);
  assign room = (cap_use > cnt_wide) ? (cap_use - cnt_wide) : '0;

  assign enc_a = cp_to_bytes(cp_a);
  assign enc_b = cp_to_bytes(cp_b);

  // Pick the code points this unit finishes and update the text state
  always_comb begin
    state_next = state;
    want_a = 1'b0;
    want_b = 1'b0;
    cp_a = Replacement;
    cp_b = Replacement;
    fit_a = 1'b0;
    fit_b = 1'b0;
    room_b = '0;
    len_a = '0;
    len_b = '0;

    if (!state.stopped) begin
      // First code point: the held surrogate, paired or not
      if (state.pending_valid) begin
        want_a = 1'b1;
        cp_a = (code_unit != 16'd0 && is_low) ? pair_cp : Replacement;
        state_next.pending_valid = 1'b0;
      end
      fit_a = !want_a || (WideW'(enc_a.len) <= room);
      if (want_a && fit_a) begin
        len_a = enc_a.len;
      end
      if (!fit_a) begin
        state_next.stopped = 1'b1;
        state_next.overflowed = 1'b1;
      end

      if (code_unit == 16'd0) begin
        state_next.stopped = 1'b1;
      end else if (fit_a && !(state.pending_valid && is_low)) begin
        // Fresh unit
        if (is_high && !last_unit) begin
          state_next.pending_high = code_unit[9:0];
          state_next.pending_valid = 1'b1;
        end else begin
          want_b = 1'b1;
          cp_b = (is_high || is_low) ? Replacement : {5'b00000, code_unit};
        end
      end

      room_b = room - WideW'(len_a);
      fit_b = WideW'(enc_b.len) <= room_b;
      if (want_b) begin
        if (fit_b) begin
          len_b = enc_b.len;
        end else begin
          state_next.stopped = 1'b1;
          state_next.overflowed = 1'b1;
          state_next.pending_valid = 1'b0;
        end
      end
    end

    total_len = RunLenW'(len_a) + RunLenW'(len_b);

    // Assemble the byte run
    run.bytes = '0;
    for (int i = 0; i < RunBytes; i++) begin
      j = 3'(i) - len_a;
      if (3'(i) < len_a) begin
        run.bytes[i] = enc_a.b[i % 4];
      end else if (j < 3'd4) begin
        run.bytes[i] = enc_b.b[j[1:0]];
      end
    end
    run.bare = (total_len == '0);
    run.len = run.bare ? RunLenW'(1) : total_len;
    run.last = last_unit;
    run.trunc = state_next.overflowed;
    run.base = state.byte_count;
    run_load = last_unit || !run.bare;

    state_next.byte_count = state.byte_count + CountBits'(total_len);
    if (last_unit) begin
      state_next = '0;
    end
  end

endmodule

[test/tb.sv]
module tb;

  typedef struct {
    logic [15:0] cu;
    logic        last;
    int          gap;
  } unit_item_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        has_data;
    logic        run_end;
    logic        done;
    logic [15:0] total;
    logic        trunc;
  } byte_rec_t;

  localparam logic [15:0] HiFirst = 16'hD800;
  localparam logic [15:0] HiLast = 16'hDBFF;
  localparam logic [15:0] LoFirst = 16'hDC00;
  localparam logic [15:0] LoLast = 16'hDFFF;
  localparam logic [20:0] ReplCp = 21'h00FFFD;
  localparam int QuietLimit = 3000;
  localparam int HoldOffCycles = 300;
  localparam int HoldOffAfter = 200;
  localparam int SettleCycles = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] code_unit = 16'd0;
  logic        last_unit = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        run_end;
  logic        text_done;
  logic [15:0] total_bytes;
  logic        truncated;

  // Stimulus backlog and expected UTF-8 bytes
  unit_item_t unit_backlog[$];
  byte_rec_t  utf8_due[$];
  logic [7:0]  cp_bytes[$];
  logic [15:0] cp_totals[$];

  // Predictor copy of the text state and the capacity register
  logic [9:0]  held_bits = '0;
  logic        held_ok = 1'b0;
  logic        halted = 1'b0;
  logic        overflowed = 1'b0;
  logic [15:0] emitted = '0;
  logic [15:0] cap_q = 16'hFFFF;

  int  n_queued = 0;
  int  n_taken = 0;
  int  n_bad = 0;
  int  calm_units = 0;
  int  quiet = 0;
  int  idle_left = 0;
  int  stall_left = 0;
  int  calm_left = 0;
  bit  hold_done = 1'b0;
  logic in_fire = 1'b0;

  utf16_to_utf8_transcoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .code_unit  (code_unit),
    .last_unit  (last_unit),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_end    (run_end),
    .text_done  (text_done),
    .total_bytes(total_bytes),
    .truncated  (truncated)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    emitted = emitted + 16'd1;
    cp_bytes.push_back(b);
    cp_totals.push_back(emitted);
  endfunction

  // Encode one code point if it fits the room left, else stop the text
  function automatic bit fit_cp(input logic [20:0] cp);
    int n;
    logic [15:0] room;
    n = (cp <= 21'h7F) ? 1 : (cp <= 21'h7FF) ? 2 : (cp <= 21'hFFFF) ? 3 : 4;
    room = (cap_q > emitted) ? cap_q - emitted : 16'd0;
    if (n > int'(room)) begin
      halted = 1'b1;
      overflowed = 1'b1;
      held_ok = 1'b0;
      return 1'b0;
    end
    case (n)
      1: add_byte(cp[7:0]);
      2: begin
        add_byte(8'hC0 | {3'b000, cp[10:6]});
        add_byte(8'h80 | {2'b00, cp[5:0]});
      end
      3: begin
        add_byte(8'hE0 | {4'b0000, cp[15:12]});
        add_byte(8'h80 | {2'b00, cp[11:6]});
        add_byte(8'h80 | {2'b00, cp[5:0]});
      end
      default: begin
        add_byte(8'hF0 | {5'b00000, cp[20:18]});
        add_byte(8'h80 | {2'b00, cp[17:12]});
        add_byte(8'h80 | {2'b00, cp[11:6]});
        add_byte(8'h80 | {2'b00, cp[5:0]});
      end
    endcase
    return 1'b1;
  endfunction

  // Work out the bytes one code unit releases and queue them as expected
  function automatic void transcode_unit(input logic [15:0] cu, input logic last);
    bit hi, lo, fresh;
    logic [20:0] cp;
    byte_rec_t rec;
    int n;
    hi = (cu >= HiFirst) && (cu <= HiLast);
    lo = (cu >= LoFirst) && (cu <= LoLast);
    cp_bytes.delete();
    cp_totals.delete();
    if (!halted) begin
      if (cu == 16'd0) begin
        if (held_ok) begin
          held_ok = 1'b0;
          void'(fit_cp(ReplCp));
        end
        halted = 1'b1;
      end else begin
        fresh = 1'b1;
        if (held_ok) begin
          held_ok = 1'b0;
          if (lo) begin
            cp = 21'h10000 + {1'b0, held_bits, 10'd0} + {5'd0, cu - LoFirst};
            void'(fit_cp(cp));
            fresh = 1'b0;
          end else if (!fit_cp(ReplCp)) begin
            fresh = 1'b0;
          end
        end
        if (fresh) begin
          if (hi) begin
            if (last) begin
              void'(fit_cp(ReplCp));
            end else begin
              held_bits = cu[9:0];
              held_ok = 1'b1;
            end
          end else if (lo) begin
            void'(fit_cp(ReplCp));
          end else begin
            void'(fit_cp({5'd0, cu}));
          end
        end
      end
    end
    n = cp_bytes.size();
    if (last && n == 0) begin
      rec = '{data: 8'd0, has_data: 1'b0, run_end: 1'b1, done: 1'b1,
              total: emitted, trunc: overflowed};
      utf8_due.push_back(rec);
    end
    for (int k = 0; k < n; k++) begin
      rec = '{data: cp_bytes[k], has_data: 1'b1, run_end: (k == n - 1),
              done: (k == n - 1) && last, total: cp_totals[k], trunc: overflowed};
      utf8_due.push_back(rec);
    end
    if (last) begin
      held_bits = '0;
      held_ok = 1'b0;
      halted = 1'b0;
      overflowed = 1'b0;
      emitted = '0;
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_bad++;
    end
  endfunction

  // Predict on accepted input transactions, check accepted output transactions
  always @(posedge clk) begin
    byte_rec_t want;
    in_fire <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      transcode_unit(code_unit, last_unit);
      n_taken++;
    end
    if (!rst && out_valid && out_ready) begin
      if (utf8_due.size() == 0) begin
        $error("unexpected output transaction: out_byte 0x%0h", out_byte);
        n_bad++;
      end else begin
        want = utf8_due.pop_front();
        check_field("out_byte", int'(want.data), int'(out_byte));
        check_field("byte_valid", int'(want.has_data), int'(byte_valid));
        check_field("run_end", int'(want.run_end), int'(run_end));
        check_field("text_done", int'(want.done), int'(text_done));
        check_field("total_bytes", int'(want.total), int'(total_bytes));
        check_field("truncated", int'(want.trunc), int'(truncated));
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Sender: offer queued units, hold each until taken, then idle its gap
  always @(negedge clk) begin
    unit_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (idle_left > 0) begin
        idle_left--;
        in_valid <= 1'b0;
      end else if (unit_backlog.size() != 0) begin
        nxt = unit_backlog.pop_front();
        in_valid <= 1'b1;
        code_unit <= nxt.cu;
        last_unit <= nxt.last;
        idle_left = nxt.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (!hold_done && n_taken >= HoldOffAfter) begin
        hold_done = 1'b1;
        stall_left = HoldOffCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_ready <= 1'b1;
      end else begin
        if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(20, 80);
        stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        out_ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  task automatic queue_unit(input logic [15:0] cu, input logic last);
    unit_item_t it;
    int g;
    if (calm_units > 0) begin
      calm_units--;
      g = 0;
    end else begin
      if ($urandom_range(0, 24) == 0) calm_units = $urandom_range(15, 40);
      g = pick_gap();
    end
    it = '{cu: cu, last: last, gap: g};
    unit_backlog.push_back(it);
    n_queued++;
  endtask

  // Random text: mostly well-formed code points and pairs, some broken units
  task automatic queue_text();
    logic [15:0] units[$];
    int len, r;
    len = $urandom_range(1, 10);
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30) units.push_back(16'($urandom_range(1, 16'h7F)));
      else if (r < 45) units.push_back(16'($urandom_range(16'h80, 16'h7FF)));
      else if (r < 65) begin
        if ($urandom_range(0, 1) == 1) units.push_back(16'($urandom_range(16'h800, 16'hD7FF)));
        else units.push_back(16'($urandom_range(16'hE000, 16'hFFFF)));
      end else if (r < 85) begin
        units.push_back(16'($urandom_range(HiFirst, HiLast)));
        units.push_back(16'($urandom_range(LoFirst, LoLast)));
      end else if (r < 90) units.push_back(16'($urandom_range(HiFirst, HiLast)));
      else if (r < 95) units.push_back(16'($urandom_range(LoFirst, LoLast)));
      else if (r < 97) units.push_back(16'd0);
      else units.push_back(16'($urandom_range(0, 16'hFFFF)));
    end
    foreach (units[k]) queue_unit(units[k], k == units.size() - 1);
  endtask

  task automatic queue_texts(input int count);
    int stop_at;
    stop_at = n_queued + count;
    while (n_queued < stop_at) queue_text();
  endtask

  // Wait for every unit to be taken and every byte to arrive, then settle
  task automatic wait_idle();
    do @(negedge clk); while (n_taken != n_queued || utf8_due.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [15:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    cap_q = v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every encoding length, pairs, lone and unpaired surrogates, stops
    set_capacity(16'hFFFF);
    queue_unit(16'h0041, 1'b0);
    queue_unit(16'h007F, 1'b0);
    queue_unit(16'h0080, 1'b0);
    queue_unit(16'h07FF, 1'b0);
    queue_unit(16'h0800, 1'b0);
    queue_unit(16'hFFFF, 1'b0);
    queue_unit(HiFirst, 1'b0);
    queue_unit(LoFirst, 1'b0);
    queue_unit(HiLast, 1'b0);
    queue_unit(LoLast, 1'b0);
    queue_unit(LoFirst, 1'b0);
    queue_unit(16'hD801, 1'b0);
    queue_unit(16'h0041, 1'b0);
    queue_unit(16'hD802, 1'b0);
    queue_unit(16'h0000, 1'b0);
    queue_unit(16'h1234, 1'b0);
    queue_unit(16'h0041, 1'b1);
    queue_unit(16'hD900, 1'b1);
    queue_unit(HiFirst, 1'b0);
    queue_unit(16'hDB00, 1'b0);
    queue_unit(16'hDC05, 1'b1);
    queue_unit(16'h0000, 1'b1);

    // Directed: no room at all, then a replacement that does not fit
    set_capacity(16'd0);
    queue_unit(16'h0041, 1'b1);
    set_capacity(16'd3);
    queue_unit(16'h0041, 1'b0);
    queue_unit(HiFirst, 1'b0);
    queue_unit(16'h0042, 1'b0);
    queue_unit(16'h0043, 1'b1);

    // Directed: capacity lowered mid-text below what was already emitted
    set_capacity(16'hFFFF);
    repeat (5) queue_unit(16'h0041, 1'b0);
    set_capacity(16'd2);
    queue_unit(16'h0041, 1'b1);

    // Random phases over several capacities
    set_capacity(16'hFFFF);
    queue_texts(120);
    set_capacity(16'($urandom_range(1, 30)));
    queue_texts(110);
    set_capacity(16'd0);
    queue_texts(30);
    set_capacity(16'($urandom_range(10, 200)));
    queue_texts(110);
    set_capacity(16'($urandom_range(0, 16'hFFFF)));
    queue_texts(80);

    wait_idle();
    repeat (20) @(negedge clk);
    if (n_bad == 0 && utf8_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[utf16_to_utf8_transcoder.f]
hw/rtl/utu8_pkg.sv
hw/rtl/utu8_step.sv
hw/rtl/utf16_to_utf8_transcoder.sv
test/tb.sv
